### src/utf8_to_ucs2_decoder_macros.svh
// assertion macros for the utf-8 to ucs-2 decoder checker
// bodies refer to clk and rst_n of the module that uses them
`ifndef UTF8_TO_UCS2_DECODER_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_MACROS_SVH

// property holds on every edge outside reset
`define U8U2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define U8U2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/u8u2_pkg.sv
// shared types and constants for the utf-8 to ucs-2 decoder
// used by the input stage, decode core, result stage and top level
package u8u2_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LIMIT   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  localparam logic [1:0]  CONT_TAG   = 2'b10;
  localparam logic [1:0]  SEQ_NONE   = 2'd0;
  localparam logic [1:0]  SEQ_TWO    = 2'd2;
  localparam logic [1:0]  SEQ_THREE  = 2'd3;
  localparam logic [15:0] MIN_TWO_B  = 16'h0080;
  localparam logic [15:0] MIN_THREE_B = 16'h0800;
  localparam logic [15:0] SURR_LO    = 16'hd800;
  localparam logic [15:0] SURR_HI    = 16'he000;
  localparam logic [15:0] MAX_UNITS_RST = 16'hffff;

  typedef struct packed {
    logic       vld;
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        string_end;
    status_t     status;
    logic [15:0] unit_count;
  } result_t;

endpackage

### src/u8u2_in_stage.sv
// input register for the decoder byte stream
// depends on u8u2_pkg
module u8u2_in_stage
  import u8u2_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       consume,
  output in_item_t   item
);

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic       fin_r;
  logic       take;

  assign in_tready = !vld_r || consume;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (consume) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_tdata;
      fin_r  <= in_tlast;
    end
  end

  assign item = '{vld: vld_r, data_byte: data_r, final_byte: fin_r};

endmodule

### src/u8u2_core.sv
// per-byte utf-8 decode logic, string state and unit limit register
// depends on u8u2_pkg
module u8u2_core
  import u8u2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  in_item_t    item,
  input  logic        res_ready,
  output logic        consume,
  output logic        res_vld,
  output result_t     res
);

  logic [15:0] max_units_r;
  logic [15:0] pv_r, pv_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  slen_r, slen_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  status_t     halt_r, halt_nxt;
  logic [15:0] cont;
  logic [15:0] unit;
  logic        u_vld;
  logic        bad;
  status_t     stat;
  logic [7:0]  b;

  assign b    = item.data_byte;
  assign cont = {pv_r[9:0], b[5:0]};

  always_comb begin
    pv_nxt   = pv_r;
    pend_nxt = pend_r;
    slen_nxt = slen_r;
    halt_nxt = halt_r;
    unit     = '0;
    u_vld    = 1'b0;
    bad      = 1'b0;
    if (halt_r == ST_OK) begin
      if (cnt_r >= max_units_r) begin
        halt_nxt = ST_LIMIT;
        pv_nxt   = '0;
        pend_nxt = '0;
        slen_nxt = SEQ_NONE;
      end else if (pend_r == 2'd0) begin
        if (!b[7]) begin
          unit  = {8'h00, b};
          u_vld = 1'b1;
        end else if (!b[6]) begin
          halt_nxt = ST_INVALID;
        end else if (!b[5]) begin
          pv_nxt   = {11'b0, b[4:0]};
          pend_nxt = 2'd1;
          slen_nxt = SEQ_TWO;
        end else if (!b[4]) begin
          pv_nxt   = {12'b0, b[3:0]};
          pend_nxt = 2'd2;
          slen_nxt = SEQ_THREE;
        end else begin
          halt_nxt = ST_INVALID;
        end
      end else if (b[7:6] != CONT_TAG) begin
        halt_nxt = ST_INVALID;
        pv_nxt   = '0;
        pend_nxt = '0;
        slen_nxt = SEQ_NONE;
      end else begin
        pv_nxt   = cont;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          // c0 80 passes as unit zero, other short two-byte forms fail
          if (slen_r == SEQ_TWO) begin
            bad = (cont != 16'h0000) && (cont < MIN_TWO_B);
          end else begin
            bad = (cont < MIN_THREE_B) || ((cont >= SURR_LO) && (cont < SURR_HI));
          end
          if (bad) begin
            halt_nxt = ST_INVALID;
          end else begin
            unit  = cont;
            u_vld = 1'b1;
          end
          pv_nxt   = '0;
          slen_nxt = SEQ_NONE;
        end
      end
    end
    cnt_nxt = cnt_r + {15'b0, u_vld};

    stat = ST_OK;
    if (item.final_byte) begin
      if ((halt_nxt == ST_OK) && (pend_nxt != 2'd0)) begin
        stat = ST_INVALID;
      end else begin
        stat = halt_nxt;
      end
    end

    res = '{code_unit: unit, unit_valid: u_vld, string_end: item.final_byte,
            status: stat, unit_count: cnt_nxt};

    // string closes: per-string state clears for the next one
    if (item.final_byte) begin
      pv_nxt   = '0;
      pend_nxt = '0;
      slen_nxt = SEQ_NONE;
      cnt_nxt  = '0;
      halt_nxt = ST_OK;
    end
  end

  assign res_vld = item.vld && (u_vld || item.final_byte);
  assign consume = item.vld && (res_ready || !(u_vld || item.final_byte));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_units_r <= MAX_UNITS_RST;
      pv_r        <= '0;
      pend_r      <= '0;
      slen_r      <= SEQ_NONE;
      cnt_r       <= '0;
      halt_r      <= ST_OK;
    end else begin
      if (cfg_wr_en) begin
        max_units_r <= cfg_wr_data;
      end
      if (consume) begin
        pv_r   <= pv_nxt;
        pend_r <= pend_nxt;
        slen_r <= slen_nxt;
        cnt_r  <= cnt_nxt;
        halt_r <= halt_nxt;
      end
    end
  end

endmodule

### src/u8u2_out_stage.sv
// result register driving the output stream
// depends on u8u2_pkg
module u8u2_out_stage
  import u8u2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_vld,
  input  result_t     res,
  output logic        res_ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  logic    vld_r, vld_nxt;
  result_t res_r;
  logic    load;

  assign res_ready = !vld_r || out_tready;
  assign load      = res_vld && res_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {res_r.unit_count, res_r.code_unit};
  assign out_tuser  = {res_r.status, res_r.unit_valid};
  assign out_tlast  = res_r.string_end;

endmodule

### src/utf8_to_ucs2_decoder.sv
// utf-8 to ucs-2 (basic plane) stream decoder, top level
// depends on u8u2_pkg, u8u2_in_stage, u8u2_core, u8u2_out_stage
//
//   channel  | direction | payload
//   in_*     | slave     | tdata: data_byte[7:0]; tlast: final_byte
//   out_*    | master    | tdata: code_unit, unit_count; tuser: unit_valid, status;
//            |           | tlast: string_end
//   cfg_*    | write     | max_units[15:0]
//
// one byte per clock sustained while the output is not stalled; a byte reaches the result
// register through the input register and one pass of decode logic.
// rst_n is synchronous: both stream registers empty, string state cleared,
// max_units back to 65535. a stalled output holds its result and any input byte
// that yields a result; back-pressure then reaches in_tready in the same cycle.
module utf8_to_ucs2_decoder
  import u8u2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] code_unit, [31:16] unit_count
  output logic [2:0]  out_tuser,   // [0] unit_valid, [2:1] status
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  in_item_t item;
  result_t  res;
  logic     consume;
  logic     res_vld;
  logic     res_ready;

  u8u2_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .consume   (consume),
    .item      (item)
  );

  u8u2_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .res_ready   (res_ready),
    .consume     (consume),
    .res_vld     (res_vld),
    .res         (res)
  );

  u8u2_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### src/u8u2_checker.sv
// port-level checks on the decoder result stream, bound to the top level
// depends on utf8_to_ucs2_decoder_macros.svh and utf8_to_ucs2_decoder
`include "utf8_to_ucs2_decoder_macros.svh"

module u8u2_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled transaction keeps its payload
  `U8U2_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")

  // no unit means a zero code unit
  `U8U2_ASSERT(a_unit_zero, !(out_tvalid && !out_tuser[0]) || (out_tdata[15:0] == 16'h0000), "code unit nonzero without unit")

  // mid-string results carry a unit and ok status
  `U8U2_ASSERT(a_mid_string, !(out_tvalid && !out_tlast) || (out_tuser[0] && (out_tuser[2:1] == 2'd0)), "bad mid-string result")

  // count includes the unit just emitted
  `U8U2_ASSERT(a_count_nonzero, !(out_tvalid && out_tuser[0]) || (out_tdata[31:16] != 16'h0000), "unit with zero count")

  // status code three is never produced
  `U8U2_ASSERT(a_status_range, !out_tvalid || (out_tuser[2:1] != 2'd3), "undefined status code")

endmodule

bind utf8_to_ucs2_decoder u8u2_checker u_chk (.*);
